// ===== hw/rtl/ccm_pkg.sv =====
package ccm_pkg;

    localparam int VOLT_BITS = 10;
    localparam int TIME_BITS = 32;
    localparam int FILT_BITS = VOLT_BITS + 8;

    localparam int LEVEL_W  = 10;
    localparam int PERIOD_W = 16;
    localparam int RISE_W   = 10;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // signed rise compare needs room for both the filter and min_rise*256
    localparam int DELTA_BITS =
        ((FILT_BITS > RISE_W + 8) ? FILT_BITS : RISE_W + 8) + 1;

    localparam logic [LEVEL_W-1:0]  FULL_LEVEL_RST   = LEVEL_W'(230);
    localparam logic [PERIOD_W-1:0] HOLD_MS_RST      = PERIOD_W'(1000);
    localparam logic [PERIOD_W-1:0] CHECK_PERIOD_RST = PERIOD_W'(1000);
    localparam logic [LEVEL_W-1:0]  LOW_LEVEL_RST    = LEVEL_W'(200);
    localparam logic [RISE_W-1:0]   MIN_RISE_RST     = RISE_W'(5);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FULL_LEVEL   = 3'd0,
        CFG_HOLD_MS      = 3'd1,
        CFG_CHECK_PERIOD = 3'd2,
        CFG_LOW_LEVEL    = 3'd3,
        CFG_MIN_RISE     = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [LEVEL_W-1:0]  full_level;
        logic [PERIOD_W-1:0] hold_ms;
        logic [PERIOD_W-1:0] check_period_ms;
        logic [LEVEL_W-1:0]  low_level;
        logic [RISE_W-1:0]   min_rise;
    } t_cfg;

    typedef struct packed {
        logic [VOLT_BITS-1:0] voltage_sample;
        logic [TIME_BITS-1:0] time_ms;
        logic                 charging_active;
    } t_in_item;

    typedef struct packed {
        logic                 charged;
        logic                 charge_fail;
        logic                 stop_charging;
        logic [FILT_BITS-1:0] filtered_level;
    } t_out_item;

endpackage

// ===== hw/rtl/ccm_cfg.sv =====
module ccm_cfg
    import ccm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_FULL_LEVEL:   n_cfg.full_level      = i_cfg_wdata[LEVEL_W-1:0];
                CFG_HOLD_MS:      n_cfg.hold_ms         = i_cfg_wdata[PERIOD_W-1:0];
                CFG_CHECK_PERIOD: n_cfg.check_period_ms = i_cfg_wdata[PERIOD_W-1:0];
                CFG_LOW_LEVEL:    n_cfg.low_level       = i_cfg_wdata[LEVEL_W-1:0];
                CFG_MIN_RISE:     n_cfg.min_rise        = i_cfg_wdata[RISE_W-1:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.full_level      <= FULL_LEVEL_RST;
            r_cfg.hold_ms         <= HOLD_MS_RST;
            r_cfg.check_period_ms <= CHECK_PERIOD_RST;
            r_cfg.low_level       <= LOW_LEVEL_RST;
            r_cfg.min_rise        <= MIN_RISE_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/ccm_core.sv =====
module ccm_core
    import ccm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_res
);

    logic [TIME_BITS-1:0] r_full_since, n_full_since;
    logic                 r_charged, n_charged;
    logic [FILT_BITS-1:0] r_filtered, n_filtered;
    logic [FILT_BITS-1:0] r_ckpt_level, n_ckpt_level;
    logic [TIME_BITS-1:0] r_ckpt_time, n_ckpt_time;
    logic                 r_fail, n_fail;

    logic [TIME_BITS-1:0]  el_full;
    logic [TIME_BITS-1:0]  el_ckpt;
    logic [FILT_BITS+7:0]  old_scaled;
    logic [FILT_BITS-1:0]  filt_chg;
    logic [DELTA_BITS-1:0] delta;
    logic [DELTA_BITS-1:0] rise_min;
    logic                  stop;

    always_comb begin
        n_full_since = r_full_since;
        n_charged    = r_charged;
        n_filtered   = r_filtered;
        n_ckpt_level = r_ckpt_level;
        n_ckpt_time  = r_ckpt_time;
        n_fail       = r_fail;
        stop         = 1'b0;

        el_full = i_item.time_ms - r_full_since;
        el_ckpt = i_item.time_ms - r_ckpt_time;

        // old*192/256 as (old*128 + old*64) >> 8
        old_scaled = {1'b0, r_filtered, 7'b0} + {2'b0, r_filtered, 6'b0};
        filt_chg   = FILT_BITS'({i_item.voltage_sample, 6'b0})
                   + old_scaled[FILT_BITS+7:8];

        if (VOLT_BITS'(i_cfg.full_level) <= i_item.voltage_sample) begin
            if (el_full >= TIME_BITS'(i_cfg.hold_ms)) begin
                n_charged = 1'b1;
            end
        end else begin
            n_full_since = i_item.time_ms;
            n_charged    = 1'b0;
        end

        if (i_item.charging_active) begin
            n_filtered = filt_chg;
        end else begin
            n_filtered = {i_item.voltage_sample, 8'b0};
        end

        delta    = DELTA_BITS'(n_filtered) - DELTA_BITS'(r_ckpt_level);
        rise_min = DELTA_BITS'({i_cfg.min_rise, 8'b0});

        if (i_item.charging_active) begin
            if (el_ckpt >= TIME_BITS'(i_cfg.check_period_ms)) begin
                n_ckpt_time  = i_item.time_ms;
                n_ckpt_level = n_filtered;
                // a falling filter gives a negative rise, which always fails the rise test
                if ((VOLT_BITS'(i_cfg.low_level) > i_item.voltage_sample)
                        && ($signed(delta) < $signed(rise_min))) begin
                    n_fail = 1'b1;
                    stop   = 1'b1;
                end
            end
        end else begin
            n_ckpt_time  = i_item.time_ms;
            n_ckpt_level = n_filtered;
        end

        o_res.charged        = n_charged;
        o_res.charge_fail    = n_fail;
        o_res.stop_charging  = stop;
        o_res.filtered_level = n_filtered;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_since <= '0;
            r_charged    <= 1'b0;
            r_filtered   <= '0;
            r_ckpt_level <= '0;
            r_ckpt_time  <= '0;
            r_fail       <= 1'b0;
        end else if (i_step) begin
            r_full_since <= n_full_since;
            r_charged    <= n_charged;
            r_filtered   <= n_filtered;
            r_ckpt_level <= n_ckpt_level;
            r_ckpt_time  <= n_ckpt_time;
            r_fail       <= n_fail;
        end
    end

    a_fail_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fail |=> r_fail)
        else $error("charge failure flag cleared without reset");

    a_stop_sets_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res.stop_charging) |=> r_fail)
        else $error("tripped check did not latch failure");

    a_stop_only_charging: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.stop_charging |-> i_item.charging_active)
        else $error("stop requested while not charging");

    a_idle_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !i_item.charging_active)
            |=> (r_ckpt_level == r_filtered && r_ckpt_time == $past(i_item.time_ms)))
        else $error("checkpoint not reloaded while idle");

endmodule

// ===== hw/rtl/capacitor_charge_monitor_unit.sv =====
// capacitor charge monitor
// input channel: i_in_valid / o_in_ready with i_in_item (voltage sample,
// millisecond timestamp, charging flag); one result item per input item
// on o_out_valid / i_out_ready with o_out_item
// configuration: i_cfg_we writes i_cfg_wdata into register i_cfg_idx at the
// clock edge; write only while no item is in flight
// latency: result valid 1 cycle after the input accept edge, taken at the
// earliest on the next edge (input register, then the single-pass step
// logic into the result register)
// throughput: one item per cycle; the filter and timers update in one cycle
// from the input register, so consecutive items chain through the state
// registers without a gap
// receiver stall: the result register holds, the input register keeps one
// more item, then o_in_ready drops until the result is taken
// reset (synchronous, active low): empties both registers, clears the filter,
// timers and the failure flag, and loads the register defaults
module capacitor_charge_monitor_unit
    import ccm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg      cfg;
    t_out_item res;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    logic      step;

    // item in the input register moves on when the result slot frees up
    assign step       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step;

    ccm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    ccm_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (r_in),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
        if (step) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== bench/ccm_checker.sv =====
module ccm_checker
    import ccm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in_item              i_in_item,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out_item             i_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_end,
    output int                    o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SCALE = 256;
    localparam int ALPHA = SCALE / 4;

    t_cfg                 cfg;
    logic [TIME_BITS-1:0] full_since;
    logic [TIME_BITS-1:0] ck_time;
    logic [FILT_BITS-1:0] filt;
    logic [FILT_BITS-1:0] ck_level;
    logic                 charged_q;
    logic                 fail_q;
    t_out_item            pending_status[$];
    int                   shown = 0;
    int                   checked = 0;
    bit                   ended = 0;

    initial o_fail_count = 0;

    // advances the monitor state by one sample and returns the status it reports
    function automatic t_out_item next_status(input t_in_item it);
        logic [TIME_BITS-1:0] dt;
        logic [31:0]          mix;
        int                   rise;
        t_out_item            r;
        r = '0;
        if (it.voltage_sample >= cfg.full_level) begin
            dt = it.time_ms - full_since;
            if (dt >= cfg.hold_ms) charged_q = 1'b1;
        end else begin
            full_since = it.time_ms;
            charged_q  = 1'b0;
        end
        if (it.charging_active) begin
            mix  = 32'(it.voltage_sample) * ALPHA + (32'(filt) * (SCALE - ALPHA)) / SCALE;
            filt = FILT_BITS'(mix);
            dt   = it.time_ms - ck_time;
            if (dt >= cfg.check_period_ms) begin
                // a falling filter gives a negative rise, always too slow
                rise     = int'(filt) - int'(ck_level);
                ck_time  = it.time_ms;
                ck_level = filt;
                if (it.voltage_sample < cfg.low_level && rise < int'(cfg.min_rise) * SCALE) begin
                    fail_q          = 1'b1;
                    r.stop_charging = 1'b1;
                end
            end
        end else begin
            filt     = FILT_BITS'(32'(it.voltage_sample) * SCALE);
            ck_time  = it.time_ms;
            ck_level = filt;
        end
        r.charged        = charged_q;
        r.charge_fail    = fail_q;
        r.filtered_level = filt;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            cfg.full_level      = FULL_LEVEL_RST;
            cfg.hold_ms         = HOLD_MS_RST;
            cfg.check_period_ms = CHECK_PERIOD_RST;
            cfg.low_level       = LOW_LEVEL_RST;
            cfg.min_rise        = MIN_RISE_RST;
            full_since = '0;
            ck_time    = '0;
            filt       = '0;
            ck_level   = '0;
            charged_q  = 1'b0;
            fail_q     = 1'b0;
            pending_status.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FULL_LEVEL:   cfg.full_level      = LEVEL_W'(i_cfg_wdata);
                    CFG_HOLD_MS:      cfg.hold_ms         = PERIOD_W'(i_cfg_wdata);
                    CFG_CHECK_PERIOD: cfg.check_period_ms = PERIOD_W'(i_cfg_wdata);
                    CFG_LOW_LEVEL:    cfg.low_level       = LEVEL_W'(i_cfg_wdata);
                    CFG_MIN_RISE:     cfg.min_rise        = RISE_W'(i_cfg_wdata);
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                checked++;
                if (pending_status.size() == 0) begin
                    o_fail_count++;
                    if (shown < 10) begin
                        shown++;
                        $display("ccm_checker: result %0d arrived with nothing expected: %p",
                                 checked, i_out_item);
                    end
                end else begin
                    want = pending_status.pop_front();
                    if (i_out_item.charged !== want.charged
                            || i_out_item.charge_fail !== want.charge_fail
                            || i_out_item.stop_charging !== want.stop_charging
                            || i_out_item.filtered_level !== want.filtered_level) begin
                        o_fail_count++;
                        if (shown < 10) begin
                            shown++;
                            $display("ccm_checker: result %0d expected charged=%0b fail=%0b",
                                     checked, want.charged, want.charge_fail,
                                     " stop=%0b filt=%0d", want.stop_charging,
                                     want.filtered_level);
                            $display("ccm_checker: result %0d      got charged=%0b fail=%0b",
                                     checked, i_out_item.charged, i_out_item.charge_fail,
                                     " stop=%0b filt=%0d", i_out_item.stop_charging,
                                     i_out_item.filtered_level);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) pending_status.push_back(next_status(i_in_item));
            if (i_end && !ended) begin
                ended = 1;
                if (pending_status.size() != 0) begin
                    o_fail_count += pending_status.size();
                    $display("ccm_checker: %0d results never arrived", pending_status.size());
                end
            end
        end
    end

endmodule

// ===== bench/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ccm_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int ITEMS       = 1150;
    localparam int PHASES      = 5;
    localparam int LIMIT       = 200000;
    localparam int HOLD_AT     = 420;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LO    = 700;
    localparam int QUIET_HI    = 900;
    localparam int IDLE_PCT    = 12;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_item = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_item;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  check_end = 1'b0;
    int                    fail_count;

    int          sent = 0;
    int          taken = 0;
    int          cycles = 0;
    int          tx_idle = IDLE_PCT;
    logic [31:0] now_ms;

    capacitor_charge_monitor_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    ccm_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_item   (o_out_item),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_end        (check_end),
        .o_fail_count (fail_count)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) taken <= taken + 1;
    end

    // receiver: random stalls, one long hold-off, and a quiet stretch
    initial begin : receiver
        int  hold_left;
        bit  held;
        hold_left = 0;
        held      = 0;
        forever begin
            @(posedge i_clk);
            if (!held && sent >= HOLD_AT) begin
                held      = 1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (sent >= QUIET_LO && sent < QUIET_HI) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    task automatic send(input logic [VOLT_BITS-1:0] v, input logic [TIME_BITS-1:0] t,
                        input logic ch);
        while ($urandom_range(0, 99) < tx_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= '{voltage_sample: v, time_ms: t, charging_active: ch};
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sent++;
        tx_idle = (sent >= QUIET_LO && sent < QUIET_HI) ? 0 : IDLE_PCT;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (taken != sent) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= d;
        @(posedge i_clk);
    endtask

    // junk in the upper bits of the narrow registers must be dropped
    task automatic set_config(input int full, input int hold, input int period,
                              input int low, input int rise);
        put_reg(CFG_FULL_LEVEL, {6'($urandom), 10'(full)});
        put_reg(CFG_HOLD_MS, 16'(hold));
        put_reg(CFG_CHECK_PERIOD, 16'(period));
        put_reg(CFG_LOW_LEVEL, {6'($urandom), 10'(low)});
        put_reg(CFG_MIN_RISE, {6'($urandom), 10'(rise)});
        // index past the last register is ignored
        put_reg(CFG_IDX_W'(int'(CFG_MIN_RISE) + 1 + int'($urandom_range(0, 2))),
                16'($urandom));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic int pick(input int top, input int lo, input int hi);
        case ($urandom_range(0, 9))
            0: return 0;
            1: return top;
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    // one charge session: a few idle samples, then a ramp or a stuck level
    task automatic charge_run(input int n);
        logic [VOLT_BITS-1:0] v;
        int                   step;
        bit                   stuck;
        v     = VOLT_BITS'($urandom_range(0, 150));
        stuck = ($urandom_range(0, 3) == 0);
        step  = $urandom_range(1, 40);
        repeat ($urandom_range(1, 3)) begin
            now_ms += $urandom_range(0, 200);
            send(v, now_ms, 1'b0);
        end
        repeat (n) begin
            now_ms += $urandom_range(0, 400);
            if (!stuck && int'(v) + step <= 1023) v = v + VOLT_BITS'(step);
            else if ($urandom_range(0, 9) == 0) v = VOLT_BITS'($urandom);
            send(v, now_ms, ($urandom_range(0, 19) != 0));
        end
    endtask

    initial begin : stimulus
        int target;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // register defaults: wrap of the timestamp, failure and its repeat
        send(10'd0, 32'd0, 1'b0);
        send(10'd1023, 32'hFFFF_FFFF, 1'b1);
        send(10'd10, 32'd999, 1'b1);
        send(10'd10, 32'd1500, 1'b1);
        send(10'd10, 32'd1999, 1'b1);
        send(10'd1023, 32'd2000, 1'b1);
        send(10'd1023, 32'd2999, 1'b1);
        send(10'd229, 32'd3000, 1'b0);
        send(10'd230, 32'd3000, 1'b0);
        settle();

        // zero hold and zero period: charged at once, check on every step
        set_config(0, 0, 0, 1023, 1023);
        send(10'd0, 32'd5, 1'b1);
        send(10'd1023, 32'd5, 1'b1);
        send(10'd1022, 32'd5, 1'b0);
        send(10'd512, 32'd6, 1'b1);
        send(10'd1, 32'd7, 1'b1);
        settle();

        set_config(1023, 65535, 65535, 0, 0);
        send(10'd1023, 32'd100, 1'b0);
        send(10'd1023, 32'd65634, 1'b1);
        send(10'd1023, 32'd65635, 1'b1);
        send(10'd1022, 32'd70000, 1'b1);
        settle();

        for (int p = 0; p < PHASES; p++) begin
            if (p == PHASES - 1)
                set_config(pick(1023, 0, 1023), pick(65535, 0, 65535), pick(65535, 0, 65535),
                           pick(1023, 0, 1023), pick(1023, 0, 1023));
            else
                set_config(pick(1023, 200, 1000), pick(65535, 0, 3000), pick(65535, 0, 2000),
                           pick(1023, 100, 900), pick(1023, 0, 60));
            now_ms = $urandom_range(0, 1) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 20000);
            target = (p + 1) * ITEMS / PHASES;
            while (sent < target) begin
                if ($urandom_range(0, 4) != 0) begin
                    charge_run($urandom_range(5, 40));
                end else begin
                    repeat ($urandom_range(1, 5))
                        send(VOLT_BITS'($urandom), $urandom, 1'($urandom));
                end
            end
            settle();
        end

        check_end <= 1'b1;
        repeat (2) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

// ===== capacitor_charge_monitor_unit.f =====
hw/rtl/ccm_pkg.sv
hw/rtl/ccm_cfg.sv
hw/rtl/ccm_core.sv
hw/rtl/capacitor_charge_monitor_unit.sv
bench/ccm_checker.sv
bench/tb.sv
